// ===== hw/rtl/json_string_literal_validator_top_macros.svh =====
// Assertion helpers. Both expect clk and arst_n in the scope of use.
`ifndef JSON_STRING_LITERAL_VALIDATOR_TOP_MACROS_SVH
`define JSON_STRING_LITERAL_VALIDATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define JSLV_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define JSLV_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define JSLV_ASSERT_IMP(lbl, ante, cons)
`define JSLV_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/jslv_pkg.sv =====
package jslv_pkg;

	localparam int unsigned LEN_W = 17;
	localparam int unsigned MAXLEN_W = 16;
	localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RST = 16'd4096;

	localparam logic [1:0] ST_SCAN   = 2'd0;
	localparam logic [1:0] ST_ACCEPT = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;
	localparam logic [1:0] ST_IDLE   = 2'd3;

	localparam logic [7:0] QUOTE      = 8'h22;
	localparam logic [7:0] BACKSLASH  = 8'h5c;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_literal;
		logic       input_ends;
	} in_item_t;

	typedef struct packed {
		logic             decoded_valid;
		logic [7:0]       decoded_byte;
		logic [1:0]       status;
		logic [LEN_W-1:0] decoded_length;
	} res_t;

	typedef struct packed {
		logic             in_literal;
		logic             escape_pending;
		logic [1:0]       bytes_remaining;
		logic [2:0]       sequence_size;
		logic [20:0]      code_point;
		logic [LEN_W-1:0] length_count;
	} lit_state_t;

endpackage

// ===== hw/rtl/jslv_if.sv =====
interface jslv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_literal;
	logic       input_ends;

	modport source(output valid, output data_byte, output start_literal,
		output input_ends, input ready);
	modport sink(input valid, input data_byte, input start_literal,
		input input_ends, output ready);
endinterface

interface jslv_out_if;
	logic        valid;
	logic        ready;
	logic        decoded_valid;
	logic [7:0]  decoded_byte;
	logic [1:0]  status;
	logic [16:0] decoded_length;

	modport source(output valid, output decoded_valid, output decoded_byte,
		output status, output decoded_length, input ready);
	modport sink(input valid, input decoded_valid, input decoded_byte,
		input status, input decoded_length, output ready);
endinterface

// ===== hw/rtl/jslv_in_stage.sv =====
// Input register: one item deep, refills in the cycle it drains.
module jslv_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  jslv_pkg::in_item_t in_item,
	input  logic               advance,
	output logic               s1_valid,
	output jslv_pkg::in_item_t s1_item
);

	logic valid_s1;
	jslv_pkg::in_item_t item_s1;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_item  = item_s1;

endmodule

// ===== hw/rtl/jslv_core.sv =====
`include "json_string_literal_validator_top_macros.svh"

// Literal state and the per-byte scan / unescape / UTF-8 step.
module jslv_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [jslv_pkg::MAXLEN_W-1:0]    cfg_wr_data,
	input  logic                             step_en,
	input  jslv_pkg::in_item_t               item,
	output jslv_pkg::res_t                   res
);

	jslv_pkg::lit_state_t st_q;
	jslv_pkg::lit_state_t st_d;
	logic [jslv_pkg::MAXLEN_W-1:0] max_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= jslv_pkg::MAX_LENGTH_RST;
		end else if (cfg_wr_en) begin
			max_length_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step_en) begin
			st_q <= st_d;
		end
	end

	always_comb begin
		logic [7:0]  b;
		logic [7:0]  d;
		logic        have_d;
		logic        utf_ok;
		logic [jslv_pkg::LEN_W-1:0] len1;
		logic [20:0] cp_n;
		logic [1:0]  br_n;
		logic [2:0]  ss_n;

		b      = item.data_byte;
		d      = b;
		have_d = 1'b0;
		utf_ok = 1'b1;
		len1   = st_q.length_count + 1'b1;
		cp_n   = st_q.code_point;
		br_n   = st_q.bytes_remaining;
		ss_n   = st_q.sequence_size;
		st_d   = st_q;
		res    = '0;
		res.status = jslv_pkg::ST_SCAN;

		if (item.start_literal) begin
			st_d = '0;
			if (b != jslv_pkg::QUOTE || item.input_ends) begin
				res.status = jslv_pkg::ST_REJECT;
			end else begin
				st_d.in_literal = 1'b1;
			end
		end else if (!st_q.in_literal) begin
			res.status = jslv_pkg::ST_IDLE;
		end else if (st_q.escape_pending) begin
			st_d.escape_pending = 1'b0;
			have_d = 1'b1;
			case (b)
				8'h22: d = 8'h22;
				8'h5c: d = 8'h5c;
				8'h2f: d = 8'h2f;
				8'h62: d = 8'h08;
				8'h66: d = 8'h0c;
				8'h6e: d = 8'h0a;
				8'h72: d = 8'h0d;
				8'h74: d = 8'h09;
				default: begin
					have_d = 1'b0;
					st_d = '0;
					res.status = jslv_pkg::ST_REJECT;
					res.decoded_length = st_q.length_count;
				end
			endcase
		end else if (b == jslv_pkg::QUOTE) begin
			st_d = '0;
			res.status = (st_q.bytes_remaining == 2'd0) ? jslv_pkg::ST_ACCEPT
				: jslv_pkg::ST_REJECT;
			res.decoded_length = st_q.length_count;
		end else if (b < jslv_pkg::CTRL_LIMIT) begin
			st_d = '0;
			res.status = jslv_pkg::ST_REJECT;
			res.decoded_length = st_q.length_count;
		end else if (b == jslv_pkg::BACKSLASH) begin
			res.decoded_length = st_q.length_count;
			if (item.input_ends) begin
				st_d = '0;
				res.status = jslv_pkg::ST_REJECT;
			end else begin
				st_d.escape_pending = 1'b1;
			end
		end else begin
			have_d = 1'b1;
		end

		if (have_d) begin
			// UTF-8 check on the decoded byte
			if (st_q.bytes_remaining == 2'd0) begin
				if (d[7] == 1'b0) begin
					utf_ok = 1'b1;
				end else if (d[7:5] == 3'b110) begin
					ss_n = 3'd2;
					cp_n = {16'd0, d[4:0]};
					br_n = 2'd1;
				end else if (d[7:4] == 4'b1110) begin
					ss_n = 3'd3;
					cp_n = {17'd0, d[3:0]};
					br_n = 2'd2;
				end else if (d[7:3] == 5'b11110) begin
					ss_n = 3'd4;
					cp_n = {18'd0, d[2:0]};
					br_n = 2'd3;
				end else begin
					utf_ok = 1'b0;
				end
			end else if (d[7:6] != 2'b10) begin
				utf_ok = 1'b0;
			end else begin
				cp_n = {st_q.code_point[14:0], d[5:0]};
				br_n = st_q.bytes_remaining - 2'd1;
				if (br_n == 2'd0) begin
					// overlong, above the Unicode range, or surrogate
					if ((ss_n == 3'd2 && cp_n < 21'h80) ||
						(ss_n == 3'd3 && cp_n < 21'h800) ||
						(ss_n == 3'd4 && cp_n < 21'h10000) ||
						cp_n > 21'h10ffff ||
						(cp_n >= 21'hd800 && cp_n <= 21'hdfff)) begin
						utf_ok = 1'b0;
					end
				end
			end

			res.decoded_length = len1;
			if (!utf_ok || len1 > {1'b0, max_length_q} || item.input_ends) begin
				st_d = '0;
				res.status = jslv_pkg::ST_REJECT;
			end else begin
				st_d.length_count    = len1;
				st_d.code_point      = cp_n;
				st_d.bytes_remaining = br_n;
				st_d.sequence_size   = ss_n;
				res.decoded_valid    = 1'b1;
				res.decoded_byte     = d;
			end
		end else if (res.status == jslv_pkg::ST_SCAN && !st_q.escape_pending
			&& st_q.in_literal && !item.start_literal && item.input_ends) begin
			// a trailing backslash is handled above; nothing else lands here
			st_d = '0;
			res.status = jslv_pkg::ST_REJECT;
		end
	end

	`JSLV_ASSERT_IMP(a_esc_in_lit, st_q.escape_pending, st_q.in_literal)
	`JSLV_ASSERT_IMP(a_seq_in_lit, st_q.bytes_remaining != 2'd0,
		st_q.in_literal && st_q.sequence_size > {1'b0, st_q.bytes_remaining})
	`JSLV_ASSERT_NXT(a_end_goes_idle, step_en && res.status != jslv_pkg::ST_SCAN,
		!st_q.in_literal)
	`JSLV_ASSERT_IMP(a_byte_only_scan, res.decoded_valid,
		res.status == jslv_pkg::ST_SCAN && res.decoded_length != '0)

endmodule

// ===== hw/rtl/jslv_out_stage.sv =====
// Result register; holds its item while the receiver stalls.
module jslv_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  jslv_pkg::res_t res,
	input  logic           out_ready,
	output logic           out_valid,
	output jslv_pkg::res_t res_q,
	output logic           advance
);

	logic valid_q;

	assign advance = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;

endmodule

// ===== hw/rtl/json_string_literal_validator_top.sv =====
// JSON string literal validator.
// in_ch  : valid/ready channel of raw text bytes, one item per byte, with
//          start_literal marking the opening quote and input_ends the last byte.
// out_ch : valid/ready channel, exactly one result item per input item:
//          decoded byte (when valid), status and running decoded length.
// cfg    : cfg_wr_en/cfg_wr_data write max_length; write only while idle.
// Path:    an accepted input item passes the input register, then the result
//          register, and its result item is presented from there.
// Throughput: one item per cycle while out_ch takes results; the literal state
//          update is a single short combinational step between the two registers.
// Reset (arst_n low): no literal open, max_length back to 4096, both
//          registers empty.
// Receiver stall: the result register holds its item; the input register
//          still takes one more item if it is empty, then in_ch.ready drops until out_ch
//          drains. Nothing is lost or repeated.
module json_string_literal_validator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [jslv_pkg::MAXLEN_W-1:0] cfg_wr_data,
	jslv_in_if.sink                       in_ch,
	jslv_out_if.source                    out_ch
);

	jslv_pkg::in_item_t in_item;
	jslv_pkg::in_item_t s1_item;
	jslv_pkg::res_t     res;
	jslv_pkg::res_t     res_q;
	logic               s1_valid;
	logic               advance;

	assign in_item.data_byte     = in_ch.data_byte;
	assign in_item.start_literal = in_ch.start_literal;
	assign in_item.input_ends    = in_ch.input_ends;

	// stage 1: input register
	jslv_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.in_item  (in_item),
		.advance  (advance),
		.s1_valid (s1_valid),
		.s1_item  (s1_item)
	);

	// literal state advances only when the item moves into the result register
	jslv_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step_en     (s1_valid && advance),
		.item        (s1_item),
		.res         (res)
	);

	// stage 2: result register
	jslv_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (s1_valid),
		.res       (res),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.res_q     (res_q),
		.advance   (advance)
	);

	assign out_ch.decoded_valid  = res_q.decoded_valid;
	assign out_ch.decoded_byte   = res_q.decoded_byte;
	assign out_ch.status         = res_q.status;
	assign out_ch.decoded_length = res_q.decoded_length;

endmodule
